// ----- hw/rtl/gtg_pkg.sv -----
// Shared types, widths, register codes and the arctangent table of the go-to-goal controller.
package gtg_pkg;

    // Number of CORDIC micro-rotations (8 to 24)
    localparam int CORDIC_STAGES = 16;
    // Square-root steps: one result bit per step, set by the 34-bit radicand
    localparam int SQRT_STEPS    = 17;
    localparam int NUM_CELLS     = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int STAGE_W       = $clog2(NUM_CELLS);
    // Clock edges from request acceptance to the result register
    localparam int RESULT_DELAY  = NUM_CELLS + 5;

    // Field and datapath widths
    localparam int POS_W   = 16;
    localparam int HD_W    = 15;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int D_W     = POS_W + 1;          // goal minus pose
    localparam int DSQ_W   = 2 * POS_W;          // one squared offset
    localparam int RAD_W   = 2 * SQRT_STEPS;     // radicand fed to the root cells
    localparam int REM_W   = SQRT_STEPS + 1;
    localparam int ROOT_W  = SQRT_STEPS;
    localparam int PRESCALE = 8;                 // Q.12 -> Q.20
    localparam int CX_W    = 28;
    localparam int Z_W     = 25;
    localparam int LIN_W   = 18;
    localparam int ANG_W   = 19;
    localparam int FRAC_LIN = 12;
    localparam int FRAC_ANG = 20;
    localparam int LPROD_W = ROOT_W + CFG_W;
    localparam int LQ_W    = LPROD_W + 1 - FRAC_LIN;
    localparam int APROD_W = Z_W + CFG_W + 1;
    localparam int AQ_W    = APROD_W - FRAC_ANG;

    localparam logic signed [Z_W-1:0]   PI_Q20    = Z_W'(3294198);
    localparam logic [LPROD_W:0]        LIN_ROUND = (LPROD_W + 1)'(2048);
    localparam logic [LQ_W-1:0]         LIN_MAX   = LQ_W'(262143);
    localparam logic signed [APROD_W-1:0] ANG_ROUND = APROD_W'(524288);
    localparam logic signed [AQ_W-1:0]  ANG_MAX   = AQ_W'(262143);
    localparam logic signed [AQ_W-1:0]  ANG_MIN   = -AQ_W'(262144);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_GOAL_X       = 16'd4096;
    localparam logic [CFG_W-1:0] RST_GOAL_Y       = 16'd4096;
    localparam logic [CFG_W-1:0] RST_ARRIVE_TOL   = 16'd205;
    localparam logic [CFG_W-1:0] RST_LINEAR_GAIN  = 16'd4096;
    localparam logic [CFG_W-1:0] RST_ANGULAR_GAIN = 16'd16384;

    typedef struct packed {
        logic [CFG_W-1:0] goal_x;
        logic [CFG_W-1:0] goal_y;
        logic [CFG_W-1:0] arrive_tolerance;
        logic [CFG_W-1:0] linear_gain;
        logic [CFG_W-1:0] angular_gain;
    } t_cfg;

    // Per-request payload handed from cell to cell
    typedef struct packed {
        logic                    arr;
        logic signed [HD_W-1:0]  hd;
        logic [RAD_W-1:0]        rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } t_cell_data;

    // round(atan(2^-i) * 2^20)
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [STAGE_W-1:0] i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            STAGE_W'(0):  a = Z_W'(823550);
            STAGE_W'(1):  a = Z_W'(486170);
            STAGE_W'(2):  a = Z_W'(256879);
            STAGE_W'(3):  a = Z_W'(130396);
            STAGE_W'(4):  a = Z_W'(65451);
            STAGE_W'(5):  a = Z_W'(32757);
            STAGE_W'(6):  a = Z_W'(16383);
            STAGE_W'(7):  a = Z_W'(8192);
            STAGE_W'(8):  a = Z_W'(4096);
            STAGE_W'(9):  a = Z_W'(2048);
            STAGE_W'(10): a = Z_W'(1024);
            STAGE_W'(11): a = Z_W'(512);
            STAGE_W'(12): a = Z_W'(256);
            STAGE_W'(13): a = Z_W'(128);
            STAGE_W'(14): a = Z_W'(64);
            STAGE_W'(15): a = Z_W'(32);
            STAGE_W'(16): a = Z_W'(16);
            STAGE_W'(17): a = Z_W'(8);
            STAGE_W'(18): a = Z_W'(4);
            STAGE_W'(19): a = Z_W'(2);
            STAGE_W'(20): a = Z_W'(1);
            default:      a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/gtg_prep.sv -----
// Front stages: goal offsets, squared distance, arrival test and CORDIC pre-rotation.
module gtg_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gtg_pkg::POS_W-1:0]         i_pose_x,
    input  logic [gtg_pkg::POS_W-1:0]         i_pose_y,
    input  logic signed [gtg_pkg::HD_W-1:0]   i_pose_heading,
    input  gtg_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output gtg_pkg::t_cell_data               o_data
);

    logic                               r_v1, r_v2, r_v3;
    logic signed [gtg_pkg::D_W-1:0]     r_dx, r_dy;
    logic signed [gtg_pkg::HD_W-1:0]    r_hd1, r_hd2;
    logic [gtg_pkg::DSQ_W-1:0]          r_dx2, r_dy2, r_tol2;
    logic signed [gtg_pkg::CX_W-1:0]    r_x2, r_y2;
    logic signed [gtg_pkg::Z_W-1:0]     r_z2;
    gtg_pkg::t_cell_data                r_data;

    logic signed [gtg_pkg::D_W-1:0]     n_dx, n_dy;
    logic signed [2*gtg_pkg::D_W-1:0]   sq_x, sq_y;
    logic signed [gtg_pkg::CX_W-1:0]    x0, y0, n_x, n_y;
    logic signed [gtg_pkg::Z_W-1:0]     n_z;
    logic [gtg_pkg::DSQ_W:0]            d2_sum;

    // Offsets from pose to goal
    assign n_dx = signed'({1'b0, i_cfg.goal_x}) - signed'({1'b0, i_pose_x});
    assign n_dy = signed'({1'b0, i_cfg.goal_y}) - signed'({1'b0, i_pose_y});

    // Square the offsets
    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;

    // Scale to Q.20 and turn left-half vectors by pi
    assign x0 = {{(gtg_pkg::CX_W - gtg_pkg::D_W - gtg_pkg::PRESCALE){r_dx[gtg_pkg::D_W-1]}},
                 r_dx, {gtg_pkg::PRESCALE{1'b0}}};
    assign y0 = {{(gtg_pkg::CX_W - gtg_pkg::D_W - gtg_pkg::PRESCALE){r_dy[gtg_pkg::D_W-1]}},
                 r_dy, {gtg_pkg::PRESCALE{1'b0}}};

    always_comb begin
        if (r_dx[gtg_pkg::D_W-1]) begin
            n_x = -x0;
            n_y = -y0;
            n_z = r_dy[gtg_pkg::D_W-1] ? -gtg_pkg::PI_Q20 : gtg_pkg::PI_Q20;
        end else begin
            n_x = x0;
            n_y = y0;
            n_z = '0;
        end
    end

    assign d2_sum = {1'b0, r_dx2} + {1'b0, r_dy2};

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_hd1 <= i_pose_heading;

        r_dx2  <= sq_x[gtg_pkg::DSQ_W-1:0];
        r_dy2  <= sq_y[gtg_pkg::DSQ_W-1:0];
        r_tol2 <= i_cfg.arrive_tolerance * i_cfg.arrive_tolerance;
        r_x2   <= n_x;
        r_y2   <= n_y;
        r_z2   <= n_z;
        r_hd2  <= r_hd1;

        r_data.arr  <= (d2_sum <= {1'b0, r_tol2});
        r_data.hd   <= r_hd2;
        r_data.rad  <= {1'b0, d2_sum};
        r_data.rem  <= '0;
        r_data.root <= '0;
        r_data.x    <= r_x2;
        r_data.y    <= r_y2;
        r_data.z    <= r_z2;
    end

    assign o_valid = r_v3;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/gtg_cell.sv -----
// One cell of the chain: a CORDIC micro-rotation and a square-root digit step.
module gtg_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [gtg_pkg::STAGE_W-1:0]       i_stage,
    input  logic                              i_valid,
    input  gtg_pkg::t_cell_data               i_data,
    output logic                              o_valid,
    output gtg_pkg::t_cell_data               o_data
);

    logic                               r_valid;
    gtg_pkg::t_cell_data                r_data;
    gtg_pkg::t_cell_data                n_data;

    logic signed [gtg_pkg::CX_W-1:0]    x_cur, y_cur, x_s, y_s;
    logic [gtg_pkg::REM_W+1:0]          trial_rem, trial_sub;

    assign x_cur = i_data.x;
    assign y_cur = i_data.y;
    assign x_s   = x_cur >>> i_stage;
    assign y_s   = y_cur >>> i_stage;

    assign trial_rem = {i_data.rem, i_data.rad[gtg_pkg::RAD_W-1 -: 2]};
    assign trial_sub = {1'b0, i_data.root, 2'b01};

    always_comb begin
        n_data = i_data;

        // Rotate toward the x axis and accumulate the angle
        if (int'(i_stage) < gtg_pkg::CORDIC_STAGES) begin
            if (!y_cur[gtg_pkg::CX_W-1]) begin
                n_data.x = x_cur + y_s;
                n_data.y = y_cur - x_s;
                n_data.z = i_data.z + gtg_pkg::atan_q20(i_stage);
            end else begin
                n_data.x = x_cur - y_s;
                n_data.y = y_cur + x_s;
                n_data.z = i_data.z - gtg_pkg::atan_q20(i_stage);
            end
        end

        // Bring down two radicand bits and settle one root bit
        if (int'(i_stage) < gtg_pkg::SQRT_STEPS) begin
            n_data.rad = i_data.rad << 2;
            if (trial_rem >= trial_sub) begin
                n_data.rem  = gtg_pkg::REM_W'(trial_rem - trial_sub);
                n_data.root = {i_data.root[gtg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_data.rem  = gtg_pkg::REM_W'(trial_rem);
                n_data.root = {i_data.root[gtg_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Hand the request to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // The rotated x component never turns negative
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_data.x[gtg_pkg::CX_W-1])
        else $error("cell x component went negative");

endmodule

// ----- hw/rtl/gtg_post.sv -----
// Back stages: gain products, rounding, saturation and the arrival override.
module gtg_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  gtg_pkg::t_cell_data               i_data,
    input  gtg_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output logic [gtg_pkg::LIN_W-1:0]         o_linear_speed,
    output logic signed [gtg_pkg::ANG_W-1:0]  o_turn_rate,
    output logic                              o_arrived
);

    logic                                 r_v4, r_v5, r_v6;
    logic                                 r_arr4, r_arr5, r_arr6;
    logic [gtg_pkg::LPROD_W-1:0]          r_lin_prod;
    logic signed [gtg_pkg::Z_W-1:0]       r_err;
    logic signed [gtg_pkg::APROD_W-1:0]   r_ang_prod;
    logic [gtg_pkg::LIN_W-1:0]            r_lin5, r_lin6;
    logic signed [gtg_pkg::ANG_W-1:0]     r_ang6;

    logic signed [gtg_pkg::Z_W-1:0]       hd_ext;
    logic signed [gtg_pkg::CFG_W:0]       gain_s;
    logic [gtg_pkg::LPROD_W:0]            lin_sum;
    logic [gtg_pkg::LQ_W-1:0]             lin_q;
    logic signed [gtg_pkg::APROD_W-1:0]   ang_sum;
    logic signed [gtg_pkg::AQ_W-1:0]      ang_q;
    logic signed [gtg_pkg::ANG_W-1:0]     n_ang;

    // Heading in Q.20
    assign hd_ext = {{(gtg_pkg::Z_W - gtg_pkg::HD_W - gtg_pkg::PRESCALE)
                      {i_data.hd[gtg_pkg::HD_W-1]}},
                     i_data.hd, {gtg_pkg::PRESCALE{1'b0}}};
    assign gain_s = {1'b0, i_cfg.angular_gain};

    // Round half up and clamp the linear speed
    assign lin_sum = {1'b0, r_lin_prod} + gtg_pkg::LIN_ROUND;
    assign lin_q   = lin_sum[gtg_pkg::LPROD_W:gtg_pkg::FRAC_LIN];

    // Round and clamp the turn rate
    assign ang_sum = r_ang_prod + gtg_pkg::ANG_ROUND;
    assign ang_q   = ang_sum[gtg_pkg::APROD_W-1:gtg_pkg::FRAC_ANG];

    always_comb begin
        priority if (ang_q > gtg_pkg::ANG_MAX) begin
            n_ang = gtg_pkg::ANG_MAX[gtg_pkg::ANG_W-1:0];
        end else if (ang_q < gtg_pkg::ANG_MIN) begin
            n_ang = gtg_pkg::ANG_MIN[gtg_pkg::ANG_W-1:0];
        end else begin
            n_ang = ang_q[gtg_pkg::ANG_W-1:0];
        end
    end

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Payload stages; zero both speeds once arrived
    always_ff @(posedge i_clk) begin
        r_arr4     <= i_data.arr;
        r_lin_prod <= i_data.root * i_cfg.linear_gain;
        r_err      <= i_data.z - hd_ext;

        r_arr5     <= r_arr4;
        r_ang_prod <= r_err * gain_s;
        r_lin5     <= (lin_q > gtg_pkg::LIN_MAX) ? gtg_pkg::LIN_MAX[gtg_pkg::LIN_W-1:0]
                                                 : lin_q[gtg_pkg::LIN_W-1:0];

        r_arr6 <= r_arr5;
        r_lin6 <= r_arr5 ? '0 : r_lin5;
        r_ang6 <= r_arr5 ? '0 : n_ang;
    end

    assign o_valid         = r_v6;
    assign o_linear_speed  = r_lin6;
    assign o_turn_rate     = r_ang6;
    assign o_arrived       = r_arr6;

endmodule

// ----- hw/rtl/go_to_goal_p_controller_top.sv -----
// Top level of the go-to-goal proportional controller: config registers and the cell chain.
//
//  Channel   Ports                                            Direction  Handshake
//  pose      i_pose_x, i_pose_y, i_pose_heading               in         start && !busy
//  command   o_linear_speed, o_turn_rate, o_arrived           out        o_done, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata                 in         i_cfg_we
//
//  One request enters every cycle; busy is always low.
//  A request passes NUM_CELLS + 6 registers (23 with 16 CORDIC stages): three
//  front stages, one chain cell per square-root or CORDIC step (the longer of
//  the two sets the chain length), three back stages. Its result is on the
//  ports straight from the last back-stage register.
//  Reset (synchronous, active low) clears the pipeline valids and loads the
//  register defaults. The result strobe cannot be stalled.
module go_to_goal_p_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gtg_pkg::POS_W-1:0]           i_pose_x,
    input  logic [gtg_pkg::POS_W-1:0]           i_pose_y,
    input  logic signed [gtg_pkg::HD_W-1:0]     i_pose_heading,
    output logic                                o_done,
    output logic [gtg_pkg::LIN_W-1:0]           o_linear_speed,
    output logic signed [gtg_pkg::ANG_W-1:0]    o_turn_rate,
    output logic                                o_arrived,
    input  logic                                i_cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gtg_pkg::CFG_W-1:0]           i_cfg_wdata
);

    gtg_pkg::t_cfg          r_cfg;
    logic                   accept;
    logic                   chain_valid [gtg_pkg::NUM_CELLS+1];
    gtg_pkg::t_cell_data    chain_data  [gtg_pkg::NUM_CELLS+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x           <= gtg_pkg::RST_GOAL_X;
            r_cfg.goal_y           <= gtg_pkg::RST_GOAL_Y;
            r_cfg.arrive_tolerance <= gtg_pkg::RST_ARRIVE_TOL;
            r_cfg.linear_gain      <= gtg_pkg::RST_LINEAR_GAIN;
            r_cfg.angular_gain     <= gtg_pkg::RST_ANGULAR_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtg_pkg::REG_GOAL_X:       r_cfg.goal_x           <= i_cfg_wdata;
                gtg_pkg::REG_GOAL_Y:       r_cfg.goal_y           <= i_cfg_wdata;
                gtg_pkg::REG_ARRIVE_TOL:   r_cfg.arrive_tolerance <= i_cfg_wdata;
                gtg_pkg::REG_LINEAR_GAIN:  r_cfg.linear_gain      <= i_cfg_wdata;
                gtg_pkg::REG_ANGULAR_GAIN: r_cfg.angular_gain     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    gtg_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_heading (i_pose_heading),
        .i_cfg          (r_cfg),
        .o_valid        (chain_valid[0]),
        .o_data         (chain_data[0])
    );

    // Chain of cells, one step each
    for (genvar k = 0; k < gtg_pkg::NUM_CELLS; k++) begin : g_cell
        gtg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (gtg_pkg::STAGE_W'(k)),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    gtg_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (chain_valid[gtg_pkg::NUM_CELLS]),
        .i_data          (chain_data[gtg_pkg::NUM_CELLS]),
        .i_cfg           (r_cfg),
        .o_valid         (o_done),
        .o_linear_speed  (o_linear_speed),
        .o_turn_rate     (o_turn_rate),
        .o_arrived       (o_arrived)
    );

    // Arrival forces both speeds to zero
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_arrived) |-> (o_linear_speed == '0 && o_turn_rate == '0))
        else $error("speed commanded while arrived");

    // Every result traces back to a request a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, gtg_pkg::RESULT_DELAY + 1))
        else $error("result without matching request");

    // Reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule
